// ===== hdl/sidau_pkg.sv =====
`timescale 1ns / 1ps

package sidau_pkg;

    // One ASCII character as it leaves the block.
    typedef logic [6:0] t_char;

    // One packed decimal digit.
    localparam int DIGIT_W = 4;
    typedef logic [DIGIT_W-1:0] t_digit;

    // Character codes.
    localparam t_char CH_ZERO  = 7'h30;
    localparam t_char CH_MINUS = 7'h2D;

    // At most this many shift-and-add-three steps per stage.
    localparam int DABBLE_STEPS = 4;

endpackage

// ===== hdl/signed_int_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps
// Stages from an accepted item to its first character: one magnitude stage, the
// conversion stages, one stage for the leading digit and the character register.
// Output: one character a cycle while the receiver does not stall, so an item
// occupies the output for 1 to MAX_DIGITS + 1 characters, set by its text length.
// Reset is synchronous and active low; it empties every stage and nothing needs clearing.

module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output sidau_pkg::t_char              o_character,
    output logic                          o_last
);

    import sidau_pkg::*;

    // Enough digits for any magnitude of VALUE_WIDTH bits.
    localparam int BCD_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int POS_W      = $clog2(BCD_DIGITS);
    localparam int NSTG       = (VALUE_WIDTH + DABBLE_STEPS - 1) / DABBLE_STEPS;

    logic                   abs_ready;
    logic                   stg_valid [NSTG+1];
    logic                   stg_ready [NSTG+1];
    logic                   stg_neg   [NSTG+1];
    logic [VALUE_WIDTH-1:0] stg_bin   [NSTG+1];
    logic [BCD_W-1:0]       stg_bcd   [NSTG+1];
    logic                   lead_valid;
    logic                   lead_ready;
    logic                   lead_neg;
    logic [BCD_W-1:0]       lead_bcd;
    logic [POS_W-1:0]       lead_pos;
    logic                   serial_ready;

    assign o_stall = !abs_ready;

    // Sign and magnitude.
    sidau_abs #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_abs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (abs_ready),
        .i_value (i_value),
        .o_valid (stg_valid[0]),
        .i_ready (stg_ready[0]),
        .o_neg   (stg_neg[0]),
        .o_mag   (stg_bin[0])
    );

    assign stg_bcd[0] = '0;

    // Binary to packed decimal, a few bits per stage.
    for (genvar k = 0; k < NSTG; k++) begin : g_dabble
        localparam int LEFT  = VALUE_WIDTH - k * DABBLE_STEPS;
        localparam int STEPS = (LEFT > DABBLE_STEPS) ? DABBLE_STEPS : LEFT;

        sidau_dabble #(
            .VALUE_WIDTH(VALUE_WIDTH),
            .BCD_DIGITS (BCD_DIGITS),
            .STEPS      (STEPS)
        ) u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .o_ready (stg_ready[k]),
            .i_neg   (stg_neg[k]),
            .i_bin   (stg_bin[k]),
            .i_bcd   (stg_bcd[k]),
            .o_valid (stg_valid[k+1]),
            .i_ready (stg_ready[k+1]),
            .o_neg   (stg_neg[k+1]),
            .o_bin   (stg_bin[k+1]),
            .o_bcd   (stg_bcd[k+1])
        );
    end

    assign stg_ready[NSTG] = lead_ready;

    // First digit to send.
    sidau_lead #(
        .BCD_DIGITS(BCD_DIGITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) u_lead (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[NSTG]),
        .o_ready (lead_ready),
        .i_neg   (stg_neg[NSTG]),
        .i_bcd   (stg_bcd[NSTG]),
        .o_valid (lead_valid),
        .i_ready (serial_ready),
        .o_neg   (lead_neg),
        .o_bcd   (lead_bcd),
        .o_pos   (lead_pos)
    );

    // Character output.
    sidau_serial #(
        .BCD_DIGITS(BCD_DIGITS)
    ) u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (lead_valid),
        .o_ready     (serial_ready),
        .i_neg       (lead_neg),
        .i_bcd       (lead_bcd),
        .i_pos       (lead_pos),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    // Every character is a minus sign or a decimal digit.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == CH_MINUS ||
                     (o_character >= CH_ZERO && o_character <= t_char'(CH_ZERO + 7'd9))))
        else $error("character outside the digit set");

    // A minus sign never ends an item's text.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_character == CH_MINUS) |-> !o_last)
        else $error("minus sign marked last");

    // A sign is followed at once by a digit of the same item.
    a_digit_after_minus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_character == CH_MINUS) |=>
            (o_valid && o_character != CH_MINUS))
        else $error("no digit straight after the minus sign");

    // An item's text leaves without gaps.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> o_valid)
        else $error("gap inside an item's text");
`endif

endmodule

// ===== hdl/sidau_abs.sv =====
`timescale 1ns / 1ps

module sidau_abs #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_neg,
    output logic [VALUE_WIDTH-1:0] o_mag
);

    logic                   r_valid;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] n_mag;

    // The stage takes an item when it is empty or its item moves on.
    assign o_ready = !r_valid || i_ready;

    // Magnitude taken unsigned, so the most negative value needs no extra bit.
    always_comb begin
        if (i_value[VALUE_WIDTH-1]) begin
            n_mag = VALUE_WIDTH'(~i_value + VALUE_WIDTH'(1));
        end else begin
            n_mag = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_neg <= i_value[VALUE_WIDTH-1];
            r_mag <= n_mag;
        end
    end

    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_mag   = r_mag;

endmodule

// ===== hdl/sidau_dabble.sv =====
`timescale 1ns / 1ps

module sidau_dabble #(
    parameter int VALUE_WIDTH = 32,
    parameter int BCD_DIGITS  = 10,
    parameter int STEPS       = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_neg,
    input  logic [VALUE_WIDTH-1:0]    i_bin,
    input  logic [BCD_DIGITS*4-1:0]   i_bcd,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_neg,
    output logic [VALUE_WIDTH-1:0]    o_bin,
    output logic [BCD_DIGITS*4-1:0]   o_bcd
);

    import sidau_pkg::*;

    localparam int BCD_W = BCD_DIGITS * DIGIT_W;

    logic                   r_valid;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_bin;
    logic [BCD_W-1:0]       r_bcd;
    logic [VALUE_WIDTH-1:0] n_bin;
    logic [BCD_W-1:0]       n_bcd;

    assign o_ready = !r_valid || i_ready;

    // A few shift-and-add-three steps: digits of five or more get three added,
    // then the top bit of the binary word shifts into the digit string.
    always_comb begin
        n_bcd = i_bcd;
        n_bin = i_bin;
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (n_bcd[d*DIGIT_W +: DIGIT_W] >= t_digit'(5)) begin
                    n_bcd[d*DIGIT_W +: DIGIT_W] = n_bcd[d*DIGIT_W +: DIGIT_W] + t_digit'(3);
                end
            end
            n_bcd = {n_bcd[BCD_W-2:0], n_bin[VALUE_WIDTH-1]};
            n_bin = {n_bin[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_neg <= i_neg;
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_bin   = r_bin;
    assign o_bcd   = r_bcd;

endmodule

// ===== hdl/sidau_lead.sv =====
`timescale 1ns / 1ps

module sidau_lead #(
    parameter int BCD_DIGITS = 10,
    parameter int MAX_DIGITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_neg,
    input  logic [BCD_DIGITS*4-1:0]       i_bcd,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_neg,
    output logic [BCD_DIGITS*4-1:0]       o_bcd,
    output logic [$clog2(BCD_DIGITS)-1:0] o_pos
);

    import sidau_pkg::*;

    localparam int BCD_W = BCD_DIGITS * DIGIT_W;
    localparam int POS_W = $clog2(BCD_DIGITS);

    logic             r_valid;
    logic             r_neg;
    logic [BCD_W-1:0] r_bcd;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;

    assign o_ready = !r_valid || i_ready;

    // Position of the first digit to send: the highest non-zero digit (the
    // lowest one for zero), held back to the digit budget when it is smaller.
    always_comb begin
        int top;
        top = 0;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (i_bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
                top = d;
            end
        end
        if (top > MAX_DIGITS - 1) begin
            n_pos = POS_W'(MAX_DIGITS - 1);
        end else begin
            n_pos = POS_W'(top);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_neg <= i_neg;
            r_bcd <= i_bcd;
            r_pos <= n_pos;
        end
    end

    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_bcd   = r_bcd;
    assign o_pos   = r_pos;

endmodule

// ===== hdl/sidau_serial.sv =====
`timescale 1ns / 1ps

module sidau_serial #(
    parameter int BCD_DIGITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_neg,
    input  logic [BCD_DIGITS*4-1:0]       i_bcd,
    input  logic [$clog2(BCD_DIGITS)-1:0] i_pos,
    output logic                          o_valid,
    input  logic                          i_stall,
    output sidau_pkg::t_char              o_character,
    output logic                          o_last
);

    import sidau_pkg::*;

    localparam int BCD_W = BCD_DIGITS * DIGIT_W;
    localparam int POS_W = $clog2(BCD_DIGITS);

    logic             r_valid;
    logic             r_minus;
    logic [BCD_W-1:0] r_bcd;
    logic [POS_W-1:0] r_pos;
    logic             w_take;
    logic             w_end;
    t_digit           w_digit;

    // A character leaves when it is shown and not stalled; the item ends on
    // the lowest digit once the minus sign has gone.
    assign w_take  = r_valid && !i_stall;
    assign w_end   = w_take && !r_minus && (r_pos == '0);
    assign o_ready = !r_valid || w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load a new item, or step from the sign to the digits and down the digits.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_minus <= i_neg;
            r_bcd   <= i_bcd;
            r_pos   <= i_pos;
        end else if (w_take) begin
            if (r_minus) begin
                r_minus <= 1'b0;
            end else begin
                r_pos <= r_pos - POS_W'(1);
            end
        end
    end

    // The character shown comes straight from the held state, so it holds
    // while the receiver stalls.
    assign w_digit     = r_bcd[{r_pos, 2'b00} +: DIGIT_W];
    assign o_character = r_minus ? CH_MINUS : t_char'(CH_ZERO + t_char'(w_digit));
    assign o_last      = !r_minus && (r_pos == '0);
    assign o_valid     = r_valid;

endmodule

// ===== tb/tb_signed_int_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_unit;

    import sidau_pkg::*;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 10;
    localparam int DIGIT_SLOTS = 20;
    localparam int RANDOM_ITEMS = 237;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int HOLDOFF_AFTER = 80;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;

    // One character of decimal text together with its end marker.
    typedef struct packed {
        t_char ch;
        logic  last;
    } t_text_char;

    // How the receiver behaves during one stretch of its stall pattern.
    typedef enum logic [1:0] {
        RX_FLOW,
        RX_LIGHT,
        RX_HEAVY
    } t_rx_mode;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          drv_valid = 1'b0;
    logic signed [VALUE_WIDTH-1:0] drv_value = '0;
    logic                          rx_stall = 1'b0;
    logic                          o_stall;
    logic                          o_valid;
    t_char                         o_character;
    logic                          o_last;

    logic signed [VALUE_WIDTH-1:0] value_queue[$];
    t_text_char                    expected_text[$];
    int                            mismatches = 0;
    int                            items_taken = 0;
    int                            total_items = 0;
    int                            burst_left = 0;
    int                            gap_left = 0;
    int                            hold_left = 0;
    int                            phase_left = 0;
    logic                          holdoff_done = 1'b0;
    t_rx_mode                      rx_mode = RX_FLOW;

    signed_int_to_decimal_ascii_unit #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (drv_valid),
        .o_stall    (o_stall),
        .i_value    (drv_value),
        .o_valid    (o_valid),
        .i_stall    (rx_stall),
        .o_character(o_character),
        .o_last     (o_last)
    );

    // Works out the decimal text of one value and queues its characters.
    function automatic void render_decimal(input logic signed [VALUE_WIDTH-1:0] value);
        logic [VALUE_WIDTH-1:0] mag;
        logic                   negative;
        int                     digs[DIGIT_SLOTS];
        int                     n;
        int                     keep;
        t_text_char             c;
        negative = value[VALUE_WIDTH-1];
        // The unsigned negation keeps the most negative value exact.
        mag = negative ? (~value + 1'b1) : value;
        n = 0;
        if (mag == 0) begin
            digs[0] = 0;
            n = 1;
        end
        while (mag != 0 && n < DIGIT_SLOTS) begin
            digs[n] = int'(mag % 10);
            mag = mag / 10;
            n++;
        end
        keep = (n > MAX_DIGITS) ? MAX_DIGITS : n;
        if (negative) begin
            c.ch = CH_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int k = keep - 1; k >= 0; k--) begin
            c.ch = CH_ZERO + t_char'(digs[k]);
            c.last = (k == 0);
            expected_text.push_back(c);
        end
    endfunction

    // Picks a random value: full-range bits, a chosen digit count, or a power of ten nearby.
    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        longint lo;
        longint hi;
        longint mag;
        int     digits;
        logic   negative;
        negative = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 2))
            0: begin
                return $urandom;
            end
            1: begin
                digits = $urandom_range(1, 10);
                lo = 1;
                for (int k = 1; k < digits; k++) begin
                    lo = lo * 10;
                end
                hi = lo * 10 - 1;
                if (digits == 1) begin
                    lo = 0;
                end
                if (hi > 64'd2147483648) begin
                    hi = 64'd2147483648;
                end
                mag = lo + longint'({32'b0, $urandom}) % (hi - lo + 1);
            end
            default: begin
                mag = 1;
                digits = $urandom_range(1, 9);
                for (int k = 0; k < digits; k++) begin
                    mag = mag * 10;
                end
                mag = mag + $urandom_range(0, 2) - 1;
            end
        endcase
        if (mag == 64'd2147483648) begin
            negative = 1'b1;
        end
        return negative ? VALUE_WIDTH'(-mag) : VALUE_WIDTH'(mag);
    endfunction

    // Notes one mismatch; only the first few are printed in full.
    task automatic report_mismatch(input string what, input t_text_char want,
                                   input t_text_char got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                     $realtime, what, want.ch, want.last, got.ch, got.last);
        end
    endtask

    // Clock.
    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        value_queue = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
                        999999999, 1000000000, -1000000000, 2147483647,
                        -2147483647 - 1, -2147483647, 2147483646,
                        32'sh5555_5555, 32'shAAAA_AAAA, 1999999999, -1234567890};
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            value_queue.push_back(pick_value());
        end
        total_items = value_queue.size();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Wait until every item has been taken and all of its text has been checked.
        while (items_taken < total_items || expected_text.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Sender: offers queued items in bursts with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && !o_stall) begin
                render_decimal(drv_value);
                items_taken <= items_taken + 1;
            end
            if (!drv_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    drv_valid <= 1'b0;
                end else if (value_queue.size() != 0) begin
                    drv_value <= value_queue.pop_front();
                    drv_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off so that the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rx_stall <= 1'b1;
        end else if (!holdoff_done && items_taken >= HOLDOFF_AFTER) begin
            holdoff_done <= 1'b1;
            hold_left <= HOLDOFF_CYCLES;
            rx_stall <= 1'b1;
        end else begin
            if (phase_left == 0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 2));
                phase_left <= $urandom_range(10, 60);
            end else begin
                phase_left <= phase_left - 1;
            end
            case (rx_mode)
                RX_FLOW:  rx_stall <= 1'b0;
                RX_LIGHT: rx_stall <= ($urandom_range(0, 3) == 0);
                default:  rx_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Checks each character taken against the oldest expected one.
    always @(posedge i_clk) begin
        t_text_char got;
        t_text_char want;
        if (i_rst_n && o_valid && !rx_stall) begin
            got.ch = o_character;
            got.last = o_last;
            if (expected_text.size() == 0) begin
                want = '0;
                report_mismatch("unexpected character", want, got);
            end else begin
                want = expected_text.pop_front();
                if (got.ch !== want.ch || got.last !== want.last) begin
                    report_mismatch("wrong character", want, got);
                end
            end
        end
    end

endmodule
